[rtl/stl_pkg.sv]
// Shared widths, codes and command/status types for the tag lookup block.
`default_nettype none
package stl_pkg;
    localparam int NUM_SETS  = 1024;
    localparam int NUM_WAYS  = 16;
    localparam int SET_W     = 10;
    localparam int WAY_W     = 4;
    localparam int TAG_W     = 32;
    localparam int ST_W      = 3;
    localparam int BLK_W     = 30;
    localparam int DVS_W     = 11;
    localparam int MC_W      = 7;
    localparam int LBB_W     = 4;
    localparam int WC_W      = 5;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_ENT = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_LCK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LBB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS = 3'd4;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_src_quo;
        logic div_by_sets;
        logic rd_en;
        logic load_res;
        logic clear_en;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic interleave;
        logic clear_last;
        logic out_blocked;
    } sts_t;
endpackage
`default_nettype wire

[rtl/set_associative_tag_lookup_top.sv]
// Top level of the set-associative tag lookup block.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_stall    op, address, target_set, target_way,
//                                               new_tag, new_transient_tag, new_state, new_lock
//   out       output     out_valid / out_stall  hit, hit_set, hit_way, hit_tag, hit_state
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Writes and ignored ops are taken in the idle state. A lookup divides its block number by
// the set count (in interleaved mode first by the modulus, then the quotient by the set
// count) in the bit-serial divider, then reads the row. After reset a clearing pass zeroes
// all 1024 state and lock rows; in_stall stays high meanwhile. A finished lookup waits in
// the result register while out_stall is high; the next item is taken once it moved there.
`default_nettype none
module set_associative_tag_lookup_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [stl_pkg::OP_W-1:0]        op,
    input  wire logic [31:0]                     address,
    input  wire logic [stl_pkg::SET_W-1:0]       target_set,
    input  wire logic [stl_pkg::WAY_W-1:0]       target_way,
    input  wire logic [stl_pkg::TAG_W-1:0]       new_tag,
    input  wire logic [stl_pkg::TAG_W-1:0]       new_transient_tag,
    input  wire logic [stl_pkg::ST_W-1:0]        new_state,
    input  wire logic                            new_lock,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 hit,
    output logic [stl_pkg::SET_W-1:0]            hit_set,
    output logic [stl_pkg::WAY_W-1:0]            hit_way,
    output logic [stl_pkg::TAG_W-1:0]            hit_tag,
    output logic [stl_pkg::ST_W-1:0]             hit_state,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [stl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stl_pkg::CFG_DAT_W-1:0]   cfg_data
);
    stl_pkg::cmd_t cmd;
    stl_pkg::sts_t sts;
    logic          in_xfer;

    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && !in_stall;

    stl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    stl_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .wr_ent            (in_xfer && op == stl_pkg::OP_WR_ENT),
        .wr_lck            (in_xfer && op == stl_pkg::OP_WR_LCK),
        .address           (address),
        .target_set        (target_set),
        .target_way        (target_way),
        .new_tag           (new_tag),
        .new_transient_tag (new_transient_tag),
        .new_state         (new_state),
        .new_lock          (new_lock),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .hit               (hit),
        .hit_set           (hit_set),
        .hit_way           (hit_way),
        .hit_tag           (hit_tag),
        .hit_state         (hit_state)
    );

    // A miss reports way zero and the invalid state.
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_way == '0 && hit_state == '0)
        else $error("miss result carries a way or state");

    // The block only takes items while the divider is quiet.
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !sts.div_busy)
        else $error("input taken while divider busy");

    // A result is loaded only into a free or draining result register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> !(out_valid && out_stall))
        else $error("pending result overwritten");
endmodule
`default_nettype wire

[rtl/stl_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module stl_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [stl_pkg::BLK_W-1:0]    dividend,
    input  wire logic [stl_pkg::DVS_W-1:0]    divisor,
    output logic                              busy,
    output logic [stl_pkg::BLK_W-1:0]         quotient,
    output logic [stl_pkg::DVS_W-1:0]         remainder
);
    localparam int CNT_W = $clog2(stl_pkg::BLK_W + 1);

    logic [stl_pkg::BLK_W-1:0] quo_reg, quo_next;
    logic [stl_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [stl_pkg::DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [stl_pkg::DVS_W:0]   partial;
    logic [stl_pkg::DVS_W:0]   diff;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[stl_pkg::BLK_W-1]};
        diff     = partial - {1'b0, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(stl_pkg::BLK_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (partial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[stl_pkg::DVS_W-1:0];
                quo_next = {quo_reg[stl_pkg::BLK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[stl_pkg::DVS_W-1:0];
                quo_next = {quo_reg[stl_pkg::BLK_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

[rtl/stl_dp.sv]
// Datapath: configuration, set index arithmetic, tag memories, way compare, result register.
`default_nettype none
module stl_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire stl_pkg::cmd_t                   cmd,
    output stl_pkg::sts_t                        sts,
    input  wire logic                            cfg_we,
    input  wire logic [stl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stl_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  wire logic                            wr_ent,
    input  wire logic                            wr_lck,
    input  wire logic [31:0]                     address,
    input  wire logic [stl_pkg::SET_W-1:0]       target_set,
    input  wire logic [stl_pkg::WAY_W-1:0]       target_way,
    input  wire logic [stl_pkg::TAG_W-1:0]       new_tag,
    input  wire logic [stl_pkg::TAG_W-1:0]       new_transient_tag,
    input  wire logic [stl_pkg::ST_W-1:0]        new_state,
    input  wire logic                            new_lock,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic                                 hit,
    output logic [stl_pkg::SET_W-1:0]            hit_set,
    output logic [stl_pkg::WAY_W-1:0]            hit_way,
    output logic [stl_pkg::TAG_W-1:0]            hit_tag,
    output logic [stl_pkg::ST_W-1:0]             hit_state
);
    localparam int NW = stl_pkg::NUM_WAYS;

    // Configuration registers.
    logic                          mode_reg;
    logic [stl_pkg::MC_W-1:0]      mods_reg;
    logic [stl_pkg::LBB_W-1:0]     lbb_reg;
    logic [stl_pkg::DVS_W-1:0]     sets_reg;
    logic [stl_pkg::WC_W-1:0]      ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            mods_reg <= stl_pkg::MC_W'(1);
            lbb_reg  <= stl_pkg::LBB_W'(6);
            sets_reg <= stl_pkg::DVS_W'(stl_pkg::NUM_SETS);
            ways_reg <= stl_pkg::WC_W'(stl_pkg::NUM_WAYS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stl_pkg::REG_MODE: mode_reg <= cfg_data[0];
                stl_pkg::REG_MODS: mods_reg <= cfg_data[stl_pkg::MC_W-1:0];
                stl_pkg::REG_LBB:  lbb_reg  <= cfg_data[stl_pkg::LBB_W-1:0];
                stl_pkg::REG_SETS: sets_reg <= cfg_data[stl_pkg::DVS_W-1:0];
                stl_pkg::REG_WAYS: ways_reg <= cfg_data[stl_pkg::WC_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated configuration values.
    logic [stl_pkg::LBB_W-1:0] lbb_sat;
    logic [stl_pkg::DVS_W-1:0] mods_sat;
    logic [stl_pkg::DVS_W-1:0] sets_sat;
    logic [stl_pkg::WC_W-1:0]  ways_sat;

    always_comb
    begin
        lbb_sat = lbb_reg;
        if (lbb_reg < stl_pkg::LBB_W'(2))
            lbb_sat = stl_pkg::LBB_W'(2);
        else if (lbb_reg > stl_pkg::LBB_W'(12))
            lbb_sat = stl_pkg::LBB_W'(12);
        mods_sat = (mods_reg == '0) ? stl_pkg::DVS_W'(1) : stl_pkg::DVS_W'(mods_reg);
        sets_sat = sets_reg;
        if (sets_reg == '0)
            sets_sat = stl_pkg::DVS_W'(1);
        else if (sets_reg > stl_pkg::DVS_W'(stl_pkg::NUM_SETS))
            sets_sat = stl_pkg::DVS_W'(stl_pkg::NUM_SETS);
        ways_sat = (ways_reg > stl_pkg::WC_W'(NW)) ? stl_pkg::WC_W'(NW) : ways_reg;
    end

    // Captured lookup.
    logic [stl_pkg::TAG_W-1:0] tag_reg;
    logic [stl_pkg::BLK_W-1:0] blk_reg;
    logic [31:0]               tag_c;
    logic [31:0]               blk_c;

    assign tag_c = address & ~((32'd1 << lbb_sat) - 32'd1);
    assign blk_c = tag_c >> lbb_sat;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_reg <= tag_c;
            blk_reg <= blk_c[stl_pkg::BLK_W-1:0];
        end
    end

    // Set index through the shared divider.
    logic [stl_pkg::BLK_W-1:0] div_quo;
    logic [stl_pkg::DVS_W-1:0] div_rem;
    logic                      div_busy;

    stl_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (cmd.div_src_quo ? div_quo : blk_reg),
        .divisor   (cmd.div_by_sets ? sets_sat : mods_sat),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    logic [stl_pkg::SET_W-1:0] set_idx;
    assign set_idx = div_rem[stl_pkg::SET_W-1:0];

    // Row-organised stores, one row per set.
    logic [NW-1:0][stl_pkg::TAG_W-1:0] tag_mem   [0:stl_pkg::NUM_SETS-1];
    logic [NW-1:0][stl_pkg::TAG_W-1:0] trans_mem [0:stl_pkg::NUM_SETS-1];
    logic [NW-1:0][stl_pkg::ST_W-1:0]  state_mem [0:stl_pkg::NUM_SETS-1];
    logic [NW-1:0]                     lock_mem  [0:stl_pkg::NUM_SETS-1];

    logic [NW-1:0][stl_pkg::TAG_W-1:0] tag_row_reg;
    logic [NW-1:0][stl_pkg::TAG_W-1:0] trans_row_reg;
    logic [NW-1:0][stl_pkg::ST_W-1:0]  state_row_reg;
    logic [NW-1:0]                     lock_row_reg;
    logic [stl_pkg::SET_W-1:0]         clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_en)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_ent)
        begin
            tag_mem[target_set][target_way]   <= new_tag;
            trans_mem[target_set][target_way] <= new_transient_tag;
        end
        if (cmd.rd_en)
        begin
            tag_row_reg   <= tag_mem[set_idx];
            trans_row_reg <= trans_mem[set_idx];
        end
    end

    // The state and lock rows are zeroed by the clearing pass after reset.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            state_mem[clr_reg] <= '0;
            lock_mem[clr_reg]  <= '0;
        end
        else
        begin
            if (wr_ent)
                state_mem[target_set][target_way] <= new_state;
            if (wr_lck)
                lock_mem[target_set][target_way] <= new_lock;
        end
        if (cmd.rd_en)
        begin
            state_row_reg <= state_mem[set_idx];
            lock_row_reg  <= lock_mem[set_idx];
        end
    end

    // Way compare; the loop runs downward so the lowest matching way wins.
    logic                      hit_c;
    logic [stl_pkg::WAY_W-1:0] way_c;
    logic [stl_pkg::ST_W-1:0]  st_c;

    always_comb
    begin
        hit_c = 1'b0;
        way_c = '0;
        st_c  = '0;
        for (int w = NW - 1; w >= 0; w--)
        begin
            if ((stl_pkg::WC_W'(w) < ways_sat) &&
                ((tag_row_reg[w] == tag_reg && state_row_reg[w] != '0) ||
                 (trans_row_reg[w] == tag_reg && lock_row_reg[w])))
            begin
                hit_c = 1'b1;
                way_c = stl_pkg::WAY_W'(w);
                st_c  = state_row_reg[w];
            end
        end
    end

    // Result register.
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_res)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            hit       <= hit_c;
            hit_set   <= set_idx;
            hit_way   <= way_c;
            hit_tag   <= tag_reg;
            hit_state <= st_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sts.div_busy    = div_busy;
    assign sts.interleave  = mode_reg;
    assign sts.clear_last  = (clr_reg == stl_pkg::SET_W'(stl_pkg::NUM_SETS - 1));
    assign sts.out_blocked = out_valid_reg && out_stall;
endmodule
`default_nettype wire

[rtl/stl_ctrl.sv]
// Controller state machine sequencing clear, division, row read and result load.
`default_nettype none
module stl_ctrl
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [stl_pkg::OP_W-1:0]  op,
    input  wire stl_pkg::sts_t             sts,
    output logic                           in_stall,
    output stl_pkg::cmd_t                  cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV1  = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && op == stl_pkg::OP_LOOKUP)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_by_sets = !sts.interleave;
                state_next      = sts.interleave ? S_DIV1 : S_DIV2;
            end
            S_DIV1:
            begin
                if (!sts.div_busy)
                begin
                    cmd.div_start   = 1'b1;
                    cmd.div_src_quo = 1'b1;
                    cmd.div_by_sets = 1'b1;
                    state_next      = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (!sts.div_busy)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_RES;
            S_RES:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the set-associative tag lookup block.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [stl_pkg::OP_W-1:0] OP_NONE = 2'd3;
    localparam int LIMIT = 1500000;
    localparam int SETTLE = 80;
    localparam int PHASES = 8;
    localparam int PER_PHASE = 140;

    typedef struct packed {
        logic [stl_pkg::OP_W-1:0]  op;
        logic [31:0]               addr;
        logic [stl_pkg::SET_W-1:0] tset;
        logic [stl_pkg::WAY_W-1:0] tway;
        logic [stl_pkg::TAG_W-1:0] ntag;
        logic [stl_pkg::TAG_W-1:0] nttag;
        logic [stl_pkg::ST_W-1:0]  nst;
        logic                      nlk;
    } item_t;

    typedef struct packed {
        logic                      hit;
        logic [stl_pkg::SET_W-1:0] set;
        logic [stl_pkg::WAY_W-1:0] way;
        logic [stl_pkg::TAG_W-1:0] tag;
        logic [stl_pkg::ST_W-1:0]  state;
    } lookup_t;

    typedef struct packed {
        item_t   it;
        logic    typed;
        lookup_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [stl_pkg::OP_W-1:0] op = OP_NONE;
    logic [31:0] address = '0;
    logic [stl_pkg::SET_W-1:0] target_set = '0;
    logic [stl_pkg::WAY_W-1:0] target_way = '0;
    logic [stl_pkg::TAG_W-1:0] new_tag = '0;
    logic [stl_pkg::TAG_W-1:0] new_transient_tag = '0;
    logic [stl_pkg::ST_W-1:0] new_state = '0;
    logic new_lock = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [stl_pkg::SET_W-1:0] hit_set;
    logic [stl_pkg::WAY_W-1:0] hit_way;
    logic [stl_pkg::TAG_W-1:0] hit_tag;
    logic [stl_pkg::ST_W-1:0] hit_state;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [stl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [stl_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    set_associative_tag_lookup_top i_dut (.*);

    // Mirror of the block's stores and registers.
    logic [stl_pkg::TAG_W-1:0] tag_mem [stl_pkg::NUM_SETS*stl_pkg::NUM_WAYS];
    logic [stl_pkg::TAG_W-1:0] ttag_mem [stl_pkg::NUM_SETS*stl_pkg::NUM_WAYS];
    logic [stl_pkg::ST_W-1:0]  st_mem [stl_pkg::NUM_SETS*stl_pkg::NUM_WAYS];
    bit                        lk_mem [stl_pkg::NUM_SETS*stl_pkg::NUM_WAYS];
    bit                        wr_mem [stl_pkg::NUM_SETS*stl_pkg::NUM_WAYS];
    logic                      mode_r = 1'b0;
    logic [stl_pkg::MC_W-1:0]  mods_r = 7'd1;
    logic [stl_pkg::LBB_W-1:0] lbb_r = 4'd6;
    logic [stl_pkg::DVS_W-1:0] sets_r = 11'd1024;
    logic [stl_pkg::WC_W-1:0]  ways_r = 5'd16;

    lookup_t lookup_q[$];
    int fails = 0;
    int cycles = 0;
    int snd_pct = 0;
    int rcv_pct = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int ways_eff();
        return (ways_r > stl_pkg::NUM_WAYS) ? stl_pkg::NUM_WAYS : int'(ways_r);
    endfunction

    // Forms the tag and the set index of an address under the current registers.
    function automatic void map_address(input logic [31:0] a, output logic [31:0] tg,
                                        output logic [stl_pkg::SET_W-1:0] st);
        int lbb;
        int unsigned mods;
        int unsigned sets;
        logic [31:0] blk;
        lbb = (lbb_r < 2) ? 2 : ((lbb_r > 12) ? 12 : int'(lbb_r));
        mods = (mods_r == 0) ? 1 : mods_r;
        sets = (sets_r == 0) ? 1 : ((sets_r > stl_pkg::NUM_SETS) ? stl_pkg::NUM_SETS : sets_r);
        tg = a & ~((32'h1 << lbb) - 32'h1);
        blk = tg >> lbb;
        if (mode_r)
            blk = blk / mods;
        st = stl_pkg::SET_W'(blk % sets);
    endfunction

    function automatic lookup_t predict_lookup(input logic [31:0] a);
        lookup_t r;
        int idx;
        r = '0;
        map_address(a, r.tag, r.set);
        for (int w = 0; w < ways_eff(); w++)
        begin
            idx = r.set * stl_pkg::NUM_WAYS + w;
            if ((tag_mem[idx] === r.tag && st_mem[idx] != 0) ||
                (lk_mem[idx] && ttag_mem[idx] === r.tag))
            begin
                r.hit = 1'b1;
                r.way = stl_pkg::WAY_W'(w);
                r.state = st_mem[idx];
                break;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= (rcv_pct > 0) && ($urandom_range(99) < rcv_pct);

    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{hit, hit_set, hit_way, hit_tag, hit_state};
            if (lookup_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer %p", $time, got);
                fails++;
            end
            else
            begin
                exp_r = lookup_q.pop_front();
                if (got.hit !== exp_r.hit || got.set !== exp_r.set || got.way !== exp_r.way
                    || got.tag !== exp_r.tag || got.state !== exp_r.state)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    fails++;
                end
            end
        end
    end

    task automatic send(input item_t it, input bit typed, input lookup_t want);
        int idx;
        if (snd_pct > 0 && $urandom_range(99) < snd_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_pct);
        end
        in_valid <= 1'b1;
        op <= it.op;
        address <= it.addr;
        target_set <= it.tset;
        target_way <= it.tway;
        new_tag <= it.ntag;
        new_transient_tag <= it.nttag;
        new_state <= it.nst;
        new_lock <= it.nlk;
        do @(posedge clk); while (in_stall);
        idx = it.tset * stl_pkg::NUM_WAYS + it.tway;
        case (it.op)
            stl_pkg::OP_LOOKUP: lookup_q.push_back(typed ? want : predict_lookup(it.addr));
            stl_pkg::OP_WR_ENT:
            begin
                tag_mem[idx] = it.ntag;
                ttag_mem[idx] = it.nttag;
                st_mem[idx] = it.nst;
                wr_mem[idx] = 1'b1;
            end
            stl_pkg::OP_WR_LCK: lk_mem[idx] = it.nlk;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [stl_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= stl_pkg::CFG_DAT_W'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            stl_pkg::REG_MODE: mode_r = val[0];
            stl_pkg::REG_MODS: mods_r = val[stl_pkg::MC_W-1:0];
            stl_pkg::REG_LBB:  lbb_r = val[stl_pkg::LBB_W-1:0];
            stl_pkg::REG_SETS: sets_r = val[stl_pkg::DVS_W-1:0];
            stl_pkg::REG_WAYS: ways_r = val[stl_pkg::WC_W-1:0];
            default: ;
        endcase
    endtask

    function automatic item_t rand_item();
        item_t it;
        it.op = stl_pkg::OP_W'($urandom_range(3));
        it.addr = $urandom;
        it.tset = stl_pkg::SET_W'($urandom);
        it.tway = stl_pkg::WAY_W'($urandom);
        it.ntag = $urandom;
        it.nttag = $urandom;
        it.nst = stl_pkg::ST_W'($urandom);
        it.nlk = 1'($urandom);
        return it;
    endfunction

    // A write that plants a hit for a random address, then lookups of that block.
    task automatic hit_sequence();
        item_t it;
        logic [31:0] tg;
        logic [stl_pkg::SET_W-1:0] st;
        lookup_t none;
        bit transient;
        none = '0;
        it = rand_item();
        it.addr = $urandom;
        map_address(it.addr, tg, st);
        transient = $urandom_range(2) == 0;
        it.op = stl_pkg::OP_WR_ENT;
        it.tset = st;
        it.tway = (ways_eff() == 0) ? stl_pkg::WAY_W'($urandom)
                                    : stl_pkg::WAY_W'($urandom_range(ways_eff() - 1));
        if (transient)
            it.nttag = tg;
        else
        begin
            it.ntag = tg;
            if (it.nst == 0)
                it.nst = stl_pkg::ST_W'($urandom_range(7, 1));
        end
        send(it, 0, none);
        if (transient)
        begin
            it.op = stl_pkg::OP_WR_LCK;
            it.nlk = 1'b1;
            send(it, 0, none);
        end
        it.op = stl_pkg::OP_LOOKUP;
        send(it, 0, none);
        if (transient && $urandom_range(1))
        begin
            it.op = stl_pkg::OP_WR_LCK;
            it.nlk = 1'b0;
            send(it, 0, none);
            it.op = stl_pkg::OP_LOOKUP;
            it.addr = tg | ($urandom & ~tg & 32'hFFF);
            send(it, 0, none);
        end
    endtask

    task automatic noise_item();
        item_t it;
        lookup_t none;
        none = '0;
        it = rand_item();
        // Locks are only set on entries whose tags have been written.
        if (it.op == stl_pkg::OP_WR_LCK && it.nlk
            && !wr_mem[it.tset * stl_pkg::NUM_WAYS + it.tway])
            it.nlk = 1'b0;
        send(it, 0, none);
    endtask

    row_t dir_rows[$];
    int settings[PHASES][5] = '{
        '{0, 1, 6, 1024, 16},
        '{1, 64, 12, 1024, 16},
        '{1, 0, 0, 0, 0},
        '{0, 127, 15, 2047, 31},
        '{1, 3, 2, 7, 5},
        '{0, 5, 4, 100, 1},
        '{1, 1, 12, 1, 16},
        '{1, 17, 8, 512, 9}
    };

    initial
    begin
        int n;
        dir_rows = '{
            '{'{stl_pkg::OP_LOOKUP, 32'h0, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0}, 1'b1,
              '{1'b0, 10'd0, 4'd0, 32'h0, 3'd0}},
            '{'{stl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0},
              1'b1, '{1'b0, 10'h3FF, 4'd0, 32'hFFFF_FFC0, 3'd0}},
            '{'{stl_pkg::OP_WR_ENT, 32'h0, 10'h3FF, 4'hF, 32'hFFFF_FFC0, 32'hFFFF_FFFF, 3'd7,
                1'b1}, 1'b0, '0},
            '{'{stl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0},
              1'b1, '{1'b1, 10'h3FF, 4'hF, 32'hFFFF_FFC0, 3'd7}},
            '{'{OP_NONE, 32'hFFFF_FFFF, 10'h3FF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7,
                1'b1}, 1'b0, '0},
            '{'{stl_pkg::OP_WR_ENT, 32'h0, 10'd1, 4'd3, 32'h0, 32'h40, 3'd0, 1'b0}, 1'b0, '0},
            '{'{stl_pkg::OP_LOOKUP, 32'h40, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0}, 1'b1,
              '{1'b0, 10'd1, 4'd0, 32'h40, 3'd0}},
            '{'{stl_pkg::OP_WR_LCK, 32'h0, 10'd1, 4'd3, 32'h0, 32'h0, 3'd0, 1'b1}, 1'b0, '0},
            // Transient hit on a way whose state is invalid.
            '{'{stl_pkg::OP_LOOKUP, 32'h40, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0}, 1'b1,
              '{1'b1, 10'd1, 4'd3, 32'h40, 3'd0}},
            '{'{stl_pkg::OP_WR_ENT, 32'h0, 10'd1, 4'd0, 32'h40, 32'h0, 3'd2, 1'b0}, 1'b0, '0},
            // The lowest matching way wins.
            '{'{stl_pkg::OP_LOOKUP, 32'h7F, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0}, 1'b1,
              '{1'b1, 10'd1, 4'd0, 32'h40, 3'd2}},
            '{'{stl_pkg::OP_WR_LCK, 32'h0, 10'd1, 4'd3, 32'h0, 32'h0, 3'd0, 1'b0}, 1'b0, '0},
            '{'{stl_pkg::OP_LOOKUP, 32'h0000_0040, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0},
              1'b0, '0},
            '{'{stl_pkg::OP_WR_ENT, 32'h0, 10'd0, 4'd0, 32'h1234_5600, 32'h0, 3'd5, 1'b0},
              1'b0, '0},
            '{'{stl_pkg::OP_LOOKUP, 32'h1234_5600, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0},
              1'b0, '0},
            '{'{stl_pkg::OP_LOOKUP, 32'h1234_563F, 10'd0, 4'd0, 32'h0, 32'h0, 3'd0, 1'b0},
              1'b0, '0}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[i])
            send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(stl_pkg::REG_MODE, settings[p][0]);
            write_reg(stl_pkg::REG_MODS, settings[p][1]);
            write_reg(stl_pkg::REG_LBB, settings[p][2]);
            write_reg(stl_pkg::REG_SETS, settings[p][3]);
            write_reg(stl_pkg::REG_WAYS, settings[p][4]);
            cfg_valid <= 1'b0;
            case (p % 4)
                0: begin snd_pct = 0; rcv_pct = 0; end
                1: begin snd_pct = 83; rcv_pct = 0; end
                2: begin snd_pct = 0; rcv_pct = 83; end
                default: begin snd_pct = 24; rcv_pct = 24; end
            endcase
            n = 0;
            while (n < PER_PHASE)
            begin
                if ($urandom_range(9) < 6)
                begin
                    hit_sequence();
                    n += 3;
                end
                else
                begin
                    noise_item();
                    n++;
                end
            end
        end
        drain();
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
